// ===== rtl/core/char_lcd_nibble_sequencer_assert.svh =====
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLNS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clns check failed");

// next-cycle implication, sampled on clk, off during reset
`define CLNS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clns check failed");

`endif

// ===== rtl/core/clns_pkg.sv =====
package clns_pkg;

  localparam int REQ_W    = 2;
  localparam int NIB_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 3;
  localparam int NUM_W    = 16;
  localparam int HOLD_W   = 11;
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 3;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 24;

  // input tdata layout
  localparam int CMD_LSB  = 0;
  localparam int CHAR_LSB = CMD_LSB + NIB_W;
  localparam int ROW_LSB  = CHAR_LSB + BYTE_W;
  localparam int COL_LSB  = ROW_LSB + ROW_W;
  localparam int NUM_LSB  = COL_LSB + BYTE_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_CMD    = 2'd0,
    REQ_CHAR   = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_NUMBER = 2'd3
  } req_t;

  localparam logic [BYTE_W-1:0] ROW1_BASE = 8'h80;
  localparam logic [BYTE_W-1:0] ROW2_BASE = 8'hC0;
  localparam logic [BYTE_W-1:0] ROW3_BASE = 8'h94;
  localparam logic [BYTE_W-1:0] ROW4_BASE = 8'hD4;

  localparam logic [HOLD_W-1:0] LONG_CMD_US  = 11'd2000;
  localparam logic [HOLD_W-1:0] SHORT_CMD_US = 11'd50;
  localparam logic [NIB_W-1:0]  LONG_CMD_MAX = 4'h2;
  localparam logic [NIB_W-1:0]  ASCII_DIGIT_HI = 4'h3;
  localparam logic [BYTE_W-1:0] DLY_RESET = 8'd1;

  localparam logic [POS_W-1:0] LAST_POS = 3'd4;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } digit_rsp_t;

  function automatic logic [NUM_W-1:0] pow10(input logic [POS_W-1:0] pos);
    logic [NUM_W-1:0] p;
    case (pos)
      3'd0:    p = 16'd10000;
      3'd1:    p = 16'd1000;
      3'd2:    p = 16'd100;
      3'd3:    p = 16'd10;
      default: p = 16'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/clns_digit_unit.sv =====
module clns_digit_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic                       next,
  input  logic [clns_pkg::NUM_W-1:0] value,
  output clns_pkg::digit_rsp_t       rsp
);
  import clns_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            state_r, state_nxt;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DIGIT_W-1:0] dig_r, dig_nxt;
  logic               seen_r, seen_nxt;
  digit_rsp_t         rsp_r, rsp_nxt;
  logic [NUM_W-1:0]   pw;
  logic               ge;

  assign pw  = pow10(pos_r);
  assign ge  = (rem_r >= pw);
  assign rsp = rsp_r;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    dig_nxt   = dig_r;
    seen_nxt  = seen_r;
    rsp_nxt   = '0;
    case (state_r)
      D_IDLE: begin
        if (load) begin
          rem_nxt   = value;
          pos_nxt   = '0;
          dig_nxt   = '0;
          seen_nxt  = 1'b0;
          state_nxt = D_RUN;
        end else if (next) begin
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        if (ge) begin
          rem_nxt = rem_r - pw;
          dig_nxt = dig_r + 4'd1;
        end else begin
          pos_nxt = pos_r + 3'd1;
          dig_nxt = '0;
          if (dig_r != '0 || seen_r || pos_r == LAST_POS) begin
            seen_nxt      = 1'b1;
            rsp_nxt.valid = 1'b1;
            rsp_nxt.digit = dig_r;
            rsp_nxt.last  = (pos_r == LAST_POS);
            state_nxt     = D_IDLE;
          end
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      rsp_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rsp_r   <= rsp_nxt;
      seen_r  <= seen_nxt;
    end
    rem_r <= rem_nxt;
    pos_r <= pos_nxt;
    dig_r <= dig_nxt;
  end

endmodule

// ===== rtl/core/char_lcd_nibble_sequencer.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | in_tuser req_type, in_tdata request fields
// out     | out | out_tvalid / out_tready| out_tdata phase fields, out_tlast last_phase
// cfg     | in  | cfg_valid / cfg_ready  | cfg_data enable_delay_us
// One request at a time; in_tready is high only while idle.
// Phases per request: command two, character four, cursor four (two commands);
// a cursor with an invalid row gives no phase and stays idle.
// Number: each digit comes from the compare/subtract unit, then gives four phases;
// at most five digits, and leading zeros are skipped.
// A phase is held while out_tready is low. Reset: synchronous, active low; delay is 1.
module char_lcd_nibble_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [3:0] command_nibble, [11:4] char_code, [14:12] row, [22:15] column,
  // [38:23] number, [39] zero
  input  logic [clns_pkg::IN_DW-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [clns_pkg::REQ_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] reg_select, [4:1] data_nibble, [5] enable_level, [16:6] hold_us,
  // [23:17] zero
  output logic [clns_pkg::OUT_DW-1:0] out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [clns_pkg::BYTE_W-1:0] cfg_data
);
  import clns_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIGIT, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic              mode_char_r, mode_char_nxt;
  logic [NIB_W-1:0]  nib_r, nib_nxt;
  logic [NIB_W-1:0]  lo_nib_r, lo_nib_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              final_r, final_nxt;
  logic              is_num_r, is_num_nxt;
  logic [BYTE_W-1:0] dly_r;

  logic              in_xfer, out_xfer, unit_end;
  logic              dig_load, dig_next;
  digit_rsp_t        rsp;
  logic [ROW_W-1:0]  row;
  logic [BYTE_W-1:0] col, base, addr;
  logic              row_ok;
  logic [NIB_W-1:0]  cur_nib;
  logic [HOLD_W-1:0] hold;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_EMIT);
  assign out_xfer   = out_tvalid && out_tready;
  assign unit_end   = mode_char_r ? (ph_r == 2'd3) : (ph_r == 2'd1);

  assign row = in_tdata[ROW_LSB +: ROW_W];
  assign col = in_tdata[COL_LSB +: BYTE_W];

  always_comb begin
    row_ok = 1'b1;
    case (row)
      3'd1:    base = ROW1_BASE;
      3'd2:    base = ROW2_BASE;
      3'd3:    base = ROW3_BASE;
      3'd4:    base = ROW4_BASE;
      default: begin
        base   = '0;
        row_ok = 1'b0;
      end
    endcase
  end

  assign addr = base + col - 8'd1;

  clns_digit_unit u_digit (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (dig_load),
    .next  (dig_next),
    .value (in_tdata[NUM_LSB +: NUM_W]),
    .rsp   (rsp)
  );

  assign dig_load = in_xfer && (req_t'(in_tuser) == REQ_NUMBER);

  always_comb begin
    state_nxt     = state_r;
    mode_char_nxt = mode_char_r;
    nib_nxt       = nib_r;
    lo_nib_nxt    = lo_nib_r;
    ph_nxt        = ph_r;
    final_nxt     = final_r;
    is_num_nxt    = is_num_r;
    dig_next      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ph_nxt     = '0;
          is_num_nxt = 1'b0;
          case (req_t'(in_tuser))
            REQ_CMD: begin
              mode_char_nxt = 1'b0;
              nib_nxt       = in_tdata[CMD_LSB +: NIB_W];
              final_nxt     = 1'b1;
              state_nxt     = S_EMIT;
            end
            REQ_CHAR: begin
              mode_char_nxt = 1'b1;
              nib_nxt       = in_tdata[CHAR_LSB + NIB_W +: NIB_W];
              lo_nib_nxt    = in_tdata[CHAR_LSB +: NIB_W];
              final_nxt     = 1'b1;
              state_nxt     = S_EMIT;
            end
            REQ_CURSOR: begin
              mode_char_nxt = 1'b0;
              nib_nxt       = addr[BYTE_W-1:NIB_W];
              lo_nib_nxt    = addr[NIB_W-1:0];
              final_nxt     = 1'b0;
              if (row_ok) begin
                state_nxt = S_EMIT;
              end
            end
            default: begin
              is_num_nxt = 1'b1;
              state_nxt  = S_DIGIT;
            end
          endcase
        end
      end
      S_DIGIT: begin
        if (rsp.valid) begin
          mode_char_nxt = 1'b1;
          nib_nxt       = ASCII_DIGIT_HI;
          lo_nib_nxt    = rsp.digit;
          final_nxt     = rsp.last;
          ph_nxt        = '0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_xfer) begin
          if (!unit_end) begin
            ph_nxt = ph_r + 2'd1;
          end else if (final_r) begin
            state_nxt = S_IDLE;
          end else if (is_num_r) begin
            dig_next  = 1'b1;
            state_nxt = S_DIGIT;
          end else begin
            nib_nxt   = lo_nib_r;
            ph_nxt    = '0;
            final_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dly_r   <= DLY_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        dly_r <= cfg_data;
      end
    end
    mode_char_r <= mode_char_nxt;
    nib_r       <= nib_nxt;
    lo_nib_r    <= lo_nib_nxt;
    ph_r        <= ph_nxt;
    final_r     <= final_nxt;
    is_num_r    <= is_num_nxt;
  end

  assign cur_nib = (mode_char_r && ph_r[1]) ? lo_nib_r : nib_r;

  always_comb begin
    if (mode_char_r) begin
      hold = {3'b000, dly_r};
    end else if (ph_r[0]) begin
      hold = '0;
    end else if (nib_r <= LONG_CMD_MAX) begin
      hold = LONG_CMD_US;
    end else begin
      hold = SHORT_CMD_US;
    end
  end

  assign out_tdata = {7'd0, hold, !ph_r[0], cur_nib, mode_char_r};
  assign out_tlast = final_r && unit_end;

endmodule

// ===== rtl/core/clns_checker.sv =====
`include "char_lcd_nibble_sequencer_assert.svh"

module clns_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_data
);

  `CLNS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `CLNS_ASSERT_NOW(a_busy_excl, in_tready, !out_tvalid)
  `CLNS_ASSERT_NEXT(a_last_ends, out_tvalid && out_tready && out_tlast, !out_tvalid)
  `CLNS_ASSERT_NOW(a_cmd_hold, out_tvalid && !out_tdata[0] && out_tdata[5],
    out_tdata[16:6] == 11'd2000 || out_tdata[16:6] == 11'd50)

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (.*);

// ===== tb/tb_lcd_phase_checker.sv =====
`timescale 1ns / 100ps

module tb_lcd_phase_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [clns_pkg::IN_DW-1:0]  in_tdata,
  input  logic [clns_pkg::REQ_W-1:0]  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [clns_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        out_tlast,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [clns_pkg::BYTE_W-1:0] cfg_data,
  output int unsigned                 fail_count,
  output int unsigned                 pending
);
  import clns_pkg::*;

  typedef struct packed {
    logic              rs;
    logic [NIB_W-1:0]  nib;
    logic              en;
    logic [HOLD_W-1:0] hold;
    logic              last;
  } phase_t;

  phase_t            phase_q[$];
  logic [BYTE_W-1:0] delay_us;

  function automatic void queue_command(input logic [NIB_W-1:0] nib);
    phase_t p;
    p.rs   = 1'b0;
    p.nib  = nib;
    p.en   = 1'b1;
    p.hold = (nib <= LONG_CMD_MAX) ? LONG_CMD_US : SHORT_CMD_US;
    p.last = 1'b0;
    phase_q.push_back(p);
    p.en   = 1'b0;
    p.hold = '0;
    phase_q.push_back(p);
  endfunction

  function automatic void queue_char(input logic [BYTE_W-1:0] code);
    phase_t p;
    p.rs   = 1'b1;
    p.hold = HOLD_W'(delay_us);
    p.last = 1'b0;
    p.nib  = code[7:4];
    p.en   = 1'b1;
    phase_q.push_back(p);
    p.en   = 1'b0;
    phase_q.push_back(p);
    p.nib  = code[3:0];
    p.en   = 1'b1;
    phase_q.push_back(p);
    p.en   = 1'b0;
    phase_q.push_back(p);
  endfunction

  function automatic void predict_phases(input req_t kind, input logic [IN_DW-1:0] data);
    int unsigned       start;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] addr;
    logic [NUM_W-1:0]  v;
    logic [3:0]        digs[5];
    int                n;
    bit                row_ok;
    start = phase_q.size();
    case (kind)
      REQ_CMD: begin
        queue_command(data[CMD_LSB +: NIB_W]);
      end
      REQ_CHAR: begin
        queue_char(data[CHAR_LSB +: BYTE_W]);
      end
      REQ_CURSOR: begin
        row_ok = 1'b1;
        case (data[ROW_LSB +: ROW_W])
          3'd1:    base = ROW1_BASE;
          3'd2:    base = ROW2_BASE;
          3'd3:    base = ROW3_BASE;
          3'd4:    base = ROW4_BASE;
          default: begin
            base = '0;
            row_ok = 1'b0;
          end
        endcase
        if (row_ok) begin
          addr = base + data[COL_LSB +: BYTE_W] - 8'd1;
          queue_command(addr[7:4]);
          queue_command(addr[3:0]);
        end
      end
      default: begin
        v = data[NUM_LSB +: NUM_W];
        n = 0;
        if (v == 0) begin
          digs[0] = 4'd0;
          n = 1;
        end
        while (v != 0 && n < 5) begin
          digs[n] = 4'(v % 10);
          v = v / 10;
          n++;
        end
        for (int i = n - 1; i >= 0; i--)
          queue_char({ASCII_DIGIT_HI, digs[i]});
      end
    endcase
    if (phase_q.size() > start)
      phase_q[phase_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    phase_t exp_p;
    if (!rst_n) begin
      phase_q.delete();
      delay_us = DLY_RESET;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        delay_us = cfg_data;
      if (in_tvalid && in_tready)
        predict_phases(req_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) begin
        if (phase_q.size() == 0) begin
          $error("phase transfer with nothing expected: tdata %h tlast %b",
                 out_tdata, out_tlast);
          fail_count++;
        end else begin
          exp_p = phase_q.pop_front();
          if (out_tdata[0] !== exp_p.rs) begin
            $error("reg_select: expected %0d, actual %0d", exp_p.rs, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[4:1] !== exp_p.nib) begin
            $error("data_nibble: expected %h, actual %h", exp_p.nib, out_tdata[4:1]);
            fail_count++;
          end
          if (out_tdata[5] !== exp_p.en) begin
            $error("enable_level: expected %0d, actual %0d", exp_p.en, out_tdata[5]);
            fail_count++;
          end
          if (out_tdata[16:6] !== exp_p.hold) begin
            $error("hold_us: expected %0d, actual %0d", exp_p.hold, out_tdata[16:6]);
            fail_count++;
          end
          if (out_tlast !== exp_p.last) begin
            $error("last_phase: expected %0d, actual %0d", exp_p.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = phase_q.size();
  end

endmodule

// ===== tb/tb_char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;
  import clns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          SETTLE_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_DW-1:0]   in_tdata;
  logic [REQ_W-1:0]   in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_DW-1:0]  out_tdata;
  logic               out_tlast;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [BYTE_W-1:0]  cfg_data;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  bit                 stall_on = 1'b1;

  char_lcd_nibble_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  tb_lcd_phase_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_DW-1:0] pack_request(input logic [NIB_W-1:0] cmd,
                                                     input logic [BYTE_W-1:0] code,
                                                     input logic [ROW_W-1:0] row,
                                                     input logic [BYTE_W-1:0] col,
                                                     input logic [NUM_W-1:0] num);
    logic [IN_DW-1:0] d;
    d = '0;
    d[CMD_LSB +: NIB_W]   = cmd;
    d[CHAR_LSB +: BYTE_W] = code;
    d[ROW_LSB +: ROW_W]   = row;
    d[COL_LSB +: BYTE_W]  = col;
    d[NUM_LSB +: NUM_W]   = num;
    return d;
  endfunction

  task automatic send_request(input req_t kind, input logic [IN_DW-1:0] data);
    @(negedge clk);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
  endtask

  // hold the sender until every predicted phase has transferred
  task automatic drain_phases();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_delay(input logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int               done;
    req_t             kind;
    logic [ROW_W-1:0] row;
    logic [BYTE_W-1:0] col;
    logic [NUM_W-1:0] num;
    done = 0;
    while (done < count) begin
      kind = req_t'($urandom_range(0, 3));
      row = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom) : ROW_W'($urandom_range(1, 4));
      col = ($urandom_range(0, 1) == 0) ? BYTE_W'($urandom_range(1, 40)) : BYTE_W'($urandom);
      case ($urandom_range(0, 3))
        0:       num = NUM_W'($urandom_range(0, 9));
        1:       num = NUM_W'($urandom_range(0, 999));
        default: num = NUM_W'($urandom);
      endcase
      send_request(kind, pack_request(NIB_W'($urandom), BYTE_W'($urandom), row, col, num));
      if (!(kind == REQ_CURSOR && (row < 3'd1 || row > 3'd4)))
        done++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_request(REQ_CMD,    pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd0));
    send_request(REQ_CMD,    pack_request(4'h2, 8'hFF, 3'd7, 8'hFF,  16'hFFFF));
    send_request(REQ_CMD,    pack_request(4'h3, 8'h00, 3'd0, 8'd0,   16'd0));
    send_request(REQ_CMD,    pack_request(4'hF, 8'h00, 3'd0, 8'd0,   16'd0));
    send_request(REQ_CHAR,   pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd0));
    send_request(REQ_CHAR,   pack_request(4'hF, 8'hFF, 3'd7, 8'hFF,  16'hFFFF));
    send_request(REQ_CHAR,   pack_request(4'h0, 8'hA5, 3'd0, 8'd0,   16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd1, 8'd1,   16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd2, 8'd16,  16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd3, 8'd20,  16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd4, 8'd255, 16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd1, 8'd0,   16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd0, 8'd5,   16'd0));
    send_request(REQ_CURSOR, pack_request(4'h0, 8'h00, 3'd5, 8'd5,   16'd0));
    send_request(REQ_CURSOR, pack_request(4'hF, 8'hFF, 3'd7, 8'hFF,  16'hFFFF));
    send_request(REQ_NUMBER, pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd0));
    send_request(REQ_NUMBER, pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd9));
    send_request(REQ_NUMBER, pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd10));
    send_request(REQ_NUMBER, pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd100));
    send_request(REQ_NUMBER, pack_request(4'h0, 8'h00, 3'd0, 8'd0,   16'd10000));
    send_request(REQ_NUMBER, pack_request(4'hF, 8'hFF, 3'd7, 8'hFF,  16'd65535));
    drain_phases();

    write_delay(8'd0);
    run_random(35);
    drain_phases();

    write_delay(8'd255);
    run_random(35);
    drain_phases();

    write_delay(BYTE_W'($urandom));
    run_random(35);
    drain_phases();

    write_delay(BYTE_W'($urandom_range(1, 254)));
    run_random(10);
    stall_on = 1'b0;
    run_random(25);
    drain_phases();

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/clns_pkg.sv
rtl/core/clns_digit_unit.sv
rtl/core/char_lcd_nibble_sequencer.sv
rtl/core/clns_checker.sv
tb/tb_lcd_phase_checker.sv
tb/tb_char_lcd_nibble_sequencer.sv
